// ===== src/pgs_pkg.sv =====
// Package for the Poisson grid Gauss-Seidel solver.
// Holds the shared Q8.24 constants, the state and register codes, the source unit
// request and response structs, and the saturating rounding helpers. No dependencies.
package pgs_pkg;

	localparam int DEF_GRID_ROWS = 64;
	localparam int DEF_GRID_COLS = 64;

	localparam int IDX_W  = 10;
	localparam int ACC_W  = 36;
	localparam int DIFF_W = 34;

	localparam logic [31:0] QONE  = 32'h0100_0000;
	localparam logic [63:0] QMAX  = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] QHALF = 64'h0000_0000_0080_0000;
	localparam logic [63:0] QFIVE = 64'h0000_0000_0500_0000;

	localparam logic [24:0] RST_ROW_STEP   = 25'd262144;
	localparam logic [24:0] RST_COL_STEP   = 25'd262144;
	localparam logic [31:0] RST_THRESHOLD  = 32'd6451;
	localparam logic [19:0] RST_MAX_SWEEPS = 20'd100000;

	typedef enum logic [1:0] {
		REG_ROW_STEP   = 2'd0,
		REG_COL_STEP   = 2'd1,
		REG_THRESHOLD  = 2'd2,
		REG_MAX_SWEEPS = 2'd3
	} pgs_reg_t;

	typedef enum logic {
		REQ_SOLVE = 1'b0,
		REQ_READ  = 1'b1
	} pgs_req_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_RESULT,
		S_FILL,
		S_CELL_UP,
		S_CELL_DN,
		S_CELL_LF,
		S_CELL_RT,
		S_CELL_CT,
		S_CELL_WAIT,
		S_CELL_WR,
		S_CELL_ACC,
		S_SWEEP_END
	} pgs_state_t;

	typedef enum logic [3:0] {
		U_IDLE,
		U_X,
		U_Y,
		U_XX,
		U_YY,
		U_HH,
		U_M,
		U_F,
		U_R,
		U_DONE
	} pgs_src_state_t;

	typedef struct packed {
		logic             start;
		logic [IDX_W-1:0] row_idx;
		logic [IDX_W-1:0] col_idx;
	} pgs_src_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] mag;
	} pgs_src_rsp_t;

	function automatic logic [31:0] sat_q(input logic [63:0] v);
		logic [31:0] r;
		r = (v > QMAX) ? QMAX[31:0] : v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] round_q(input logic [63:0] p);
		logic [63:0] s;
		s = (p + QHALF) >> 24;
		return sat_q(s);
	endfunction

endpackage

// ===== src/pgs_source_unit.sv =====
// Source term unit: computes the magnitude of -10*(x^2+y^2+5)*h^2 for one cell.
// Uses one registered 32x32 multiplier, shared by all the multiply steps. Depends on pgs_pkg.
module pgs_source_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [24:0]          row_step,
	input  logic [24:0]          col_step,
	input  pgs_pkg::pgs_src_req_t src_req,
	output pgs_pkg::pgs_src_rsp_t src_rsp
);

	pgs_pkg::pgs_src_state_t state_q, state_nxt;

	logic [pgs_pkg::IDX_W-1:0] i_q, j_q;
	logic [63:0] prod_q;
	logic [31:0] mul_a, mul_b;
	logic [31:0] x_q, y_q, xx_q, t_q, hh_q, m_q, mag_q;
	logic [63:0] t_sum, t_ten;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgs_pkg::U_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pgs_pkg::U_IDLE: begin
				if (src_req.start) state_nxt = pgs_pkg::U_X;
			end
			pgs_pkg::U_X: begin
				mul_a = 32'(i_q);
				mul_b = 32'(row_step);
				state_nxt = pgs_pkg::U_Y;
			end
			pgs_pkg::U_Y: begin
				mul_a = 32'(j_q);
				mul_b = 32'(col_step);
				state_nxt = pgs_pkg::U_XX;
			end
			pgs_pkg::U_XX: begin
				mul_a = x_q;
				mul_b = x_q;
				state_nxt = pgs_pkg::U_YY;
			end
			pgs_pkg::U_YY: begin
				mul_a = y_q;
				mul_b = y_q;
				state_nxt = pgs_pkg::U_HH;
			end
			pgs_pkg::U_HH: begin
				mul_a = 32'(row_step);
				mul_b = 32'(row_step);
				state_nxt = pgs_pkg::U_M;
			end
			pgs_pkg::U_M: state_nxt = pgs_pkg::U_F;
			pgs_pkg::U_F: begin
				mul_a = m_q;
				mul_b = hh_q;
				state_nxt = pgs_pkg::U_R;
			end
			pgs_pkg::U_R: state_nxt = pgs_pkg::U_DONE;
			pgs_pkg::U_DONE: state_nxt = pgs_pkg::U_IDLE;
			default: state_nxt = pgs_pkg::U_IDLE;
		endcase
	end

	assign t_sum = 64'(xx_q) + 64'(pgs_pkg::round_q(prod_q)) + pgs_pkg::QFIVE;
	assign t_ten = {29'd0, t_q, 3'd0} + {31'd0, t_q, 1'd0};

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			pgs_pkg::U_IDLE: begin
				i_q <= src_req.row_idx;
				j_q <= src_req.col_idx;
			end
			pgs_pkg::U_Y: x_q <= pgs_pkg::sat_q(prod_q);
			pgs_pkg::U_XX: y_q <= pgs_pkg::sat_q(prod_q);
			pgs_pkg::U_YY: xx_q <= pgs_pkg::round_q(prod_q);
			pgs_pkg::U_HH: t_q <= pgs_pkg::sat_q(t_sum);
			pgs_pkg::U_M: begin
				hh_q <= pgs_pkg::round_q(prod_q);
				m_q <= pgs_pkg::sat_q(t_ten);
			end
			pgs_pkg::U_R: mag_q <= pgs_pkg::round_q(prod_q);
			default: begin
			end
		endcase
	end

	assign src_rsp.done = (state_q == pgs_pkg::U_DONE);
	assign src_rsp.mag  = mag_q;

endmodule

// ===== src/poisson_grid_gauss_seidel_solver.sv =====
// Top level of the Poisson grid solver: request sequencer, grid memory and result register.
// Depends on pgs_pkg and pgs_source_unit.
//
// Requests arrive on req_valid/req_stall with req_type, row and col. A read request
// returns one cell; a solve request resets the grid and runs Gauss-Seidel sweeps.
// Every request gives exactly one response on rsp_valid/rsp_stall carrying
// cell_value, sweeps_done and converged; a solve reports cell_value zero.
// A read passes through the READ and RESULT states before the response register
// is loaded (only RESULT when the cell lies outside the grid). A solve first
// resets the grid in FILL, then updates each interior cell in the CELL states
// and ends each sweep in SWEEP_END; the pace of each cell is set by the source
// term unit and the five reads that share the single memory read port.
// One request is worked on at a time. After reset the block clears the grid
// and holds req_stall high until done. The configuration port (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready and should be written only
// while the block is idle. If the receiver stalls, a finished response waits
// in the output register and the block takes the next request; a second
// response waits until the first has been taken.
module poisson_grid_gauss_seidel_solver #(
	parameter int GRID_ROWS = pgs_pkg::DEF_GRID_ROWS,
	parameter int GRID_COLS = pgs_pkg::DEF_GRID_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] cell_value,
	output logic [19:0] sweeps_done,
	output logic        converged,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int DEPTH = GRID_ROWS * GRID_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(GRID_ROWS);
	localparam int CW    = $clog2(GRID_COLS);
	localparam int SUM_W = pgs_pkg::DIFF_W + AW;
	localparam int ACC_W = pgs_pkg::ACC_W;

	pgs_pkg::pgs_state_t state_q, state_nxt;

	logic [24:0] row_step_q, col_step_q;
	logic [31:0] thresh_q;
	logic [19:0] max_sweeps_q;

	logic [31:0] grid_mem [DEPTH];
	logic [31:0] rdata_q;
	logic        mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0] mem_wdata;

	logic [AW-1:0] fill_q, addr_q, req_addr;
	logic [CW-1:0] fcol_q, cj_q;
	logic [RW-1:0] ci_q;
	logic          fill_last, cell_last, req_in_range;

	logic signed [ACC_W-1:0] acc_q, acc_rnd, acc_shr;
	logic signed [31:0]      q_val, old_q;
	logic signed [pgs_pkg::DIFF_W-1:0] diff_q;
	logic signed [SUM_W-1:0] sum_q;
	logic        [SUM_W-1:0] sum_abs;
	logic        [19:0]      sweeps_q, sweeps_inc;
	logic                    sweep_conv, sweep_stop;

	logic [19:0] last_count_q;
	logic        last_conv_q;
	logic [31:0] cell_q;
	logic        rsp_valid_q;
	logic        rsp_load;

	pgs_pkg::pgs_src_req_t src_req;
	pgs_pkg::pgs_src_rsp_t src_rsp;

	pgs_source_unit u_source (
		.clk      (clk),
		.arst_n   (arst_n),
		.row_step (row_step_q),
		.col_step (col_step_q),
		.src_req  (src_req),
		.src_rsp  (src_rsp)
	);

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != pgs_pkg::S_IDLE);

	assign req_in_range = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
	assign req_addr     = AW'(int'(row) * GRID_COLS + int'(col));
	assign fill_last    = (fill_q == AW'(DEPTH - 1));
	assign cell_last    = (ci_q == RW'(GRID_ROWS - 2)) && (cj_q == CW'(GRID_COLS - 2));

	assign acc_rnd = acc_q + ACC_W'(2);
	assign acc_shr = acc_rnd >>> 2;
	always_comb begin
		if (acc_shr > 36'sh0_7FFF_FFFF) begin
			q_val = 32'sh7FFF_FFFF;
		end else if (acc_shr < 36'shF_8000_0000) begin
			q_val = 32'sh8000_0000;
		end else begin
			q_val = acc_shr[31:0];
		end
	end

	assign sum_abs    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign sweep_conv = (sum_abs <= SUM_W'(thresh_q));
	assign sweeps_inc = sweeps_q + 20'd1;
	assign sweep_stop = sweep_conv || (sweeps_inc >= max_sweeps_q);
	assign rsp_load   = (state_q == pgs_pkg::S_RESULT) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgs_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		mem_we    = 1'b0;
		mem_waddr = fill_q;
		mem_wdata = (fcol_q == CW'(GRID_COLS - 1)) ? pgs_pkg::QONE : 32'd0;
		mem_re    = 1'b0;
		mem_raddr = addr_q;
		src_req.start   = 1'b0;
		src_req.row_idx = pgs_pkg::IDX_W'(ci_q);
		src_req.col_idx = pgs_pkg::IDX_W'(cj_q);
		case (state_q)
			pgs_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				if (fill_last) state_nxt = pgs_pkg::S_IDLE;
			end
			pgs_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req_type == pgs_pkg::REQ_SOLVE) begin
						state_nxt = pgs_pkg::S_FILL;
					end else if (req_in_range) begin
						mem_re    = 1'b1;
						mem_raddr = req_addr;
						state_nxt = pgs_pkg::S_READ;
					end else begin
						state_nxt = pgs_pkg::S_RESULT;
					end
				end
			end
			pgs_pkg::S_READ: state_nxt = pgs_pkg::S_RESULT;
			pgs_pkg::S_RESULT: begin
				if (!rsp_valid_q || !rsp_stall) state_nxt = pgs_pkg::S_IDLE;
			end
			pgs_pkg::S_FILL: begin
				mem_we = 1'b1;
				if (fill_last) begin
					state_nxt = (max_sweeps_q == 20'd0) ? pgs_pkg::S_RESULT
						: pgs_pkg::S_CELL_UP;
				end
			end
			pgs_pkg::S_CELL_UP: begin
				mem_re        = 1'b1;
				mem_raddr     = addr_q - AW'(GRID_COLS);
				src_req.start = 1'b1;
				state_nxt     = pgs_pkg::S_CELL_DN;
			end
			pgs_pkg::S_CELL_DN: begin
				mem_re    = 1'b1;
				mem_raddr = addr_q + AW'(GRID_COLS);
				state_nxt = pgs_pkg::S_CELL_LF;
			end
			pgs_pkg::S_CELL_LF: begin
				mem_re    = 1'b1;
				mem_raddr = addr_q - AW'(1);
				state_nxt = pgs_pkg::S_CELL_RT;
			end
			pgs_pkg::S_CELL_RT: begin
				mem_re    = 1'b1;
				mem_raddr = addr_q + AW'(1);
				state_nxt = pgs_pkg::S_CELL_CT;
			end
			pgs_pkg::S_CELL_CT: begin
				mem_re    = 1'b1;
				state_nxt = pgs_pkg::S_CELL_WAIT;
			end
			pgs_pkg::S_CELL_WAIT: begin
				if (src_rsp.done) state_nxt = pgs_pkg::S_CELL_WR;
			end
			pgs_pkg::S_CELL_WR: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = q_val;
				state_nxt = pgs_pkg::S_CELL_ACC;
			end
			pgs_pkg::S_CELL_ACC: begin
				state_nxt = cell_last ? pgs_pkg::S_SWEEP_END : pgs_pkg::S_CELL_UP;
			end
			pgs_pkg::S_SWEEP_END: begin
				state_nxt = sweep_stop ? pgs_pkg::S_RESULT : pgs_pkg::S_CELL_UP;
			end
			default: state_nxt = pgs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= grid_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_step_q   <= pgs_pkg::RST_ROW_STEP;
			col_step_q   <= pgs_pkg::RST_COL_STEP;
			thresh_q     <= pgs_pkg::RST_THRESHOLD;
			max_sweeps_q <= pgs_pkg::RST_MAX_SWEEPS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pgs_pkg::REG_ROW_STEP:   row_step_q   <= cfg_data[24:0];
				pgs_pkg::REG_COL_STEP:   col_step_q   <= cfg_data[24:0];
				pgs_pkg::REG_THRESHOLD:  thresh_q     <= cfg_data;
				pgs_pkg::REG_MAX_SWEEPS: max_sweeps_q <= cfg_data[19:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			fcol_q       <= '0;
			addr_q       <= AW'(GRID_COLS + 1);
			ci_q         <= RW'(1);
			cj_q         <= CW'(1);
			sweeps_q     <= '0;
			last_count_q <= '0;
			last_conv_q  <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (mem_we && ((state_q == pgs_pkg::S_CLEAR) || (state_q == pgs_pkg::S_FILL))) begin
				fill_q <= fill_last ? '0 : fill_q + AW'(1);
				fcol_q <= (fcol_q == CW'(GRID_COLS - 1)) ? '0 : fcol_q + CW'(1);
			end
			if (state_q == pgs_pkg::S_FILL && fill_last) begin
				addr_q   <= AW'(GRID_COLS + 1);
				ci_q     <= RW'(1);
				cj_q     <= CW'(1);
				sweeps_q <= '0;
				if (max_sweeps_q == 20'd0) begin
					last_count_q <= '0;
					last_conv_q  <= 1'b0;
				end
			end
			if (state_q == pgs_pkg::S_CELL_ACC) begin
				if (cell_last) begin
					addr_q <= AW'(GRID_COLS + 1);
					ci_q   <= RW'(1);
					cj_q   <= CW'(1);
				end else if (cj_q == CW'(GRID_COLS - 2)) begin
					addr_q <= addr_q + AW'(3);
					ci_q   <= ci_q + RW'(1);
					cj_q   <= CW'(1);
				end else begin
					addr_q <= addr_q + AW'(1);
					cj_q   <= cj_q + CW'(1);
				end
			end
			if (state_q == pgs_pkg::S_SWEEP_END) begin
				sweeps_q <= sweeps_inc;
				if (sweep_stop) begin
					last_count_q <= sweeps_inc;
					last_conv_q  <= sweep_conv;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pgs_pkg::S_IDLE: cell_q <= '0;
			pgs_pkg::S_READ: cell_q <= rdata_q;
			pgs_pkg::S_FILL: sum_q <= '0;
			pgs_pkg::S_CELL_DN: acc_q <= ACC_W'(signed'(rdata_q));
			pgs_pkg::S_CELL_LF, pgs_pkg::S_CELL_RT, pgs_pkg::S_CELL_CT: begin
				acc_q <= acc_q + ACC_W'(signed'(rdata_q));
			end
			pgs_pkg::S_CELL_WAIT: begin
				old_q <= rdata_q;
				if (src_rsp.done) acc_q <= acc_q + ACC_W'(src_rsp.mag);
			end
			pgs_pkg::S_CELL_WR: begin
				diff_q <= pgs_pkg::DIFF_W'(q_val) - pgs_pkg::DIFF_W'(old_q);
			end
			pgs_pkg::S_CELL_ACC: sum_q <= sum_q + SUM_W'(diff_q);
			pgs_pkg::S_SWEEP_END: sum_q <= '0;
			default: begin
			end
		endcase
		if (rsp_load) begin
			cell_value  <= cell_q;
			sweeps_done <= last_count_q;
			converged   <= last_conv_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

	// The five reads of a cell never touch the entry written in the same cycle.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("grid memory read and write hit the same entry");

	// The source unit must finish only while the sequencer waits for it.
	a_src_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		src_rsp.done |-> (state_q == pgs_pkg::S_CELL_WAIT))
		else $error("source term finished outside the wait state");

	// A cell is written back only after the source term was added.
	a_wr_after_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pgs_pkg::S_CELL_WR) |-> ($past(state_q) == pgs_pkg::S_CELL_WAIT))
		else $error("cell written without its source term");

	// A new response appears only when the result state loads it.
	a_rsp_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == pgs_pkg::S_RESULT))
		else $error("response raised outside the result state");

	// Memory writes occur only while clearing, filling or writing back a cell.
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == pgs_pkg::S_CLEAR) || (state_q == pgs_pkg::S_FILL)
			|| (state_q == pgs_pkg::S_CELL_WR)))
		else $error("grid memory written in an unexpected state");

endmodule
